>>> src/msnp_pkg.sv
package msnp_pkg;

    localparam int GROUP_SLOTS_DEF      = 128;
    localparam int PORT_COUNT_DEF       = 5;
    localparam int MEMBERS_PER_PORT_DEF = 4;

    localparam logic [30:0] EXPIRE_RESET = 31'd26000;

    localparam logic [1:0] OP_JOIN       = 2'd0;
    localparam logic [1:0] OP_LEAVE      = 2'd1;
    localparam logic [1:0] OP_LEAVE_LAST = 2'd2;
    localparam logic [1:0] OP_SWEEP      = 2'd3;

    localparam logic [1:0] ACT_REMOVE = 2'd1;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_EXPIRE = 1'b1;

    localparam int KEY_W    = 60;
    localparam int STAMP_W  = 32;
    localparam int MEMBER_W = 50;

    typedef struct packed {
        logic        used;
        logic        entered;
        logic [47:0] host;
    } member_t;

    typedef struct packed {
        logic hit;
        logic free;
    } chain_t;

    function automatic logic reserved_group(input logic [47:0] g);
        logic v4;
        logic v6;
        begin
            v4 = (g[47:40] == 8'h01) && (g[23:8] == 16'h0000) &&
                 ((g[7:0] <= 8'h02) || (g[7:0] == 8'h16) || (g[7:0] >= 8'hFB));
            v6 = (g[47:40] == 8'h33) && (g[31:8] == 24'h000000) &&
                 ((g[7:0] <= 8'h16) || (g[7:0] == 8'hFB));
            return v4 || v6;
        end
    endfunction

endpackage

>>> src/msnp_ram.sv
module msnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/msnp_cell.sv
module msnp_cell (
    input  msnp_pkg::member_t cur,
    input  logic [47:0]       host_mac,
    input  logic              is_join,
    input  msnp_pkg::chain_t  chain_in,
    output msnp_pkg::chain_t  chain_out,
    output msnp_pkg::member_t nxt,
    output logic              entered_before,
    output logic              entered_after
);

    logic hit_here;
    logic free_here;

    always_comb begin
        hit_here  = cur.used && (cur.host == host_mac) && !chain_in.hit;
        free_here = !cur.used && !chain_in.free;
        chain_out.hit  = chain_in.hit | hit_here;
        chain_out.free = chain_in.free | free_here;
        nxt = cur;
        if (free_here) begin
            nxt.used    = 1'b1;
            nxt.entered = is_join;
            nxt.host    = host_mac;
        end else if (hit_here) begin
            nxt.entered = is_join;
        end
        entered_before = cur.used && cur.entered;
        entered_after  = nxt.used && nxt.entered;
    end

endmodule

>>> src/msnp_chain.sv
module msnp_chain #(
    parameter int MEMBERS = 4
) (
    input  logic [MEMBERS*msnp_pkg::MEMBER_W-1:0] row_in,
    input  logic [47:0]                           host_mac,
    input  logic                                  is_join,
    output logic [MEMBERS*msnp_pkg::MEMBER_W-1:0] row_out,
    output logic                                  any_before,
    output logic                                  any_after
);

    msnp_pkg::member_t [MEMBERS-1:0] cur;
    msnp_pkg::member_t [MEMBERS-1:0] nxt;
    msnp_pkg::chain_t  [MEMBERS:0]   hit_c;
    msnp_pkg::chain_t  [MEMBERS:0]   free_c;
    msnp_pkg::chain_t  [MEMBERS-1:0] unused_c;
    logic [MEMBERS-1:0] eb;
    logic [MEMBERS-1:0] ea;
    logic [MEMBERS-1:0] hb;

    assign cur = row_in;
    assign hit_c[0] = '{hit: 1'b0, free: 1'b1};

    genvar i;
    generate
        for (i = 0; i < MEMBERS; i++) begin : g_hit
            assign hb[i] = cur[i].used && (cur[i].host == host_mac) && !hit_c[i].hit;
            assign hit_c[i+1] = '{hit: hit_c[i].hit | hb[i], free: 1'b1};
        end
    endgenerate

    assign free_c[0] = '{hit: 1'b0, free: hit_c[MEMBERS].hit | !is_join};

    generate
        for (i = 0; i < MEMBERS; i++) begin : g_cell
            msnp_cell u_cell (
                .cur            (cur[i]),
                .host_mac       (host_mac),
                .is_join        (is_join),
                .chain_in       (free_c[i]),
                .chain_out      (unused_c[i]),
                .nxt            (nxt[i]),
                .entered_before (eb[i]),
                .entered_after  (ea[i])
            );
            assign free_c[i+1] = '{hit: unused_c[i].hit, free: unused_c[i].free};
        end
    endgenerate

    assign row_out    = nxt;
    assign any_before = |eb;
    assign any_after  = |ea;

endmodule

>>> src/multicast_snooping_membership_table.sv
// Sequence: an event scans the group pool one slot at a time, in a read and a compare state
//   set by the single group RAM read port; a join that opens a new group also clears the
//   group's member rows, one per port; a sweep reads each port's member row, then emits a
//   remove word per member port up to the last one, waiting while the result word is stalled.
// Throughput: one input word at a time; the next is taken once the current is done.
// Reset: aresetn synchronous active low clears group valid bits and control; no
//   clearing pass, member rows are cleared when a group slot is allocated.
module multicast_snooping_membership_table #(
    parameter int GROUP_SLOTS      = msnp_pkg::GROUP_SLOTS_DEF,
    parameter int PORT_COUNT       = msnp_pkg::PORT_COUNT_DEF,
    parameter int MEMBERS_PER_PORT = msnp_pkg::MEMBERS_PER_PORT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [47:0] s_group_mac,
    input  logic [47:0] s_host_mac,
    input  logic [11:0] s_vlan,
    input  logic [2:0]  s_port,
    input  logic [6:0]  s_slot_index,
    input  logic [31:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_out_group_mac,
    output logic [11:0] m_out_vlan,
    output logic [2:0]  m_out_port,
    output logic [1:0]  m_action,
    output logic        m_last
);

    localparam int SW    = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int ROWS  = GROUP_SLOTS * PORT_COUNT;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int GW    = msnp_pkg::KEY_W + msnp_pkg::STAMP_W;
    localparam int ROW_W = MEMBERS_PER_PORT * msnp_pkg::MEMBER_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SC_RD  = 4'd1;
    localparam logic [3:0] ST_SC_CMP = 4'd2;
    localparam logic [3:0] ST_CLR    = 4'd3;
    localparam logic [3:0] ST_M_RD   = 4'd4;
    localparam logic [3:0] ST_M_WAIT = 4'd5;
    localparam logic [3:0] ST_M_WB   = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_SW_RD  = 4'd8;
    localparam logic [3:0] ST_SW_WT  = 4'd9;
    localparam logic [3:0] ST_SW_ACC = 4'd10;
    localparam logic [3:0] ST_SW_EV  = 4'd11;
    localparam logic [3:0] ST_SW_OUT = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic        enable_reg;
    logic [30:0] expire_reg;
    logic [GROUP_SLOTS-1:0] gvalid_reg, gvalid_next;

    logic [1:0]  op_reg;
    logic [47:0] gmac_reg, hmac_reg;
    logic [11:0] vlan_reg;
    logic [2:0]  port_reg;
    logic [31:0] now_reg;
    logic [SW:0]   scan_reg, scan_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          free_ok_reg, free_ok_next;
    logic [SW-1:0] free_reg, free_next;
    logic [PW:0]   pc_reg, pc_next;
    logic [PORT_COUNT-1:0] mask_reg, mask_next;
    logic          exist_reg, exist_next;

    logic          g_we;
    logic [SW-1:0] g_waddr, g_raddr;
    logic [GW-1:0] g_wdata, g_rdata;
    logic          m_we;
    logic [RW-1:0] m_waddr, m_raddr;
    logic [ROW_W-1:0] m_wdata, m_rdata, row_new;
    logic any_before, any_after;

    logic        out_free;
    logic        mv_reg;
    logic [47:0] omac_reg;
    logic [11:0] ovlan_reg;
    logic [2:0]  oport_reg;
    logic [1:0]  oact_reg;
    logic        olast_reg;
    logic        load;
    logic [47:0] ld_mac;
    logic [11:0] ld_vlan;
    logic [2:0]  ld_port;
    logic [1:0]  ld_act;
    logic        ld_last;

    logic [59:0]   key;
    logic [RW-1:0] row_base;
    logic [31:0]   diff;
    logic [SW-1:0] scan_idx;
    logic [PW-1:0] pc_idx;

    msnp_ram #(.WIDTH(GW), .DEPTH(GROUP_SLOTS), .AW(SW)) u_gram (
        .aclk(aclk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    msnp_ram #(.WIDTH(ROW_W), .DEPTH(ROWS), .AW(RW)) u_mram (
        .aclk(aclk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    msnp_chain #(.MEMBERS(MEMBERS_PER_PORT)) u_chain (
        .row_in(m_rdata), .host_mac(hmac_reg), .is_join(op_reg == msnp_pkg::OP_JOIN),
        .row_out(row_new), .any_before(any_before), .any_after(any_after)
    );

    assign key      = {vlan_reg, gmac_reg};
    assign scan_idx = scan_reg[SW-1:0];
    assign pc_idx   = pc_reg[PW-1:0];
    assign row_base = RW'(slot_reg) * RW'(PORT_COUNT);
    assign diff     = g_rdata[31:0] + {1'b0, expire_reg} - now_reg;
    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        gvalid_next  = gvalid_reg;
        scan_next    = scan_reg;
        slot_next    = slot_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        pc_next      = pc_reg;
        mask_next    = mask_reg;
        exist_next   = exist_reg;
        g_we    = 1'b0;
        g_waddr = slot_reg;
        g_wdata = {key, now_reg};
        g_raddr = slot_reg;
        m_we    = 1'b0;
        m_waddr = row_base + RW'(port_reg);
        m_wdata = row_new;
        m_raddr = row_base + RW'(port_reg);
        load    = 1'b0;
        ld_mac  = gmac_reg;
        ld_vlan = vlan_reg;
        ld_port = port_reg;
        ld_act  = op_reg;
        ld_last = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && enable_reg) begin
                    scan_next    = '0;
                    free_ok_next = 1'b0;
                    pc_next      = '0;
                    mask_next    = '0;
                    slot_next    = SW'(s_slot_index);
                    if (s_op == msnp_pkg::OP_SWEEP) begin
                        if ({{(SW+8){1'b0}}, s_slot_index} < (SW+15)'(GROUP_SLOTS) &&
                            gvalid_reg[SW'(s_slot_index)]) begin
                            state_next = ST_SW_RD;
                        end
                    end else if (!s_host_mac[40] && !msnp_pkg::reserved_group(s_group_mac)
                                 && ({1'b0, s_port} < 4'(PORT_COUNT))) begin
                        state_next = ST_SC_RD;
                    end
                end
            end
            ST_SC_RD: begin
                g_raddr    = scan_idx;
                state_next = ST_SC_CMP;
            end
            ST_SC_CMP: begin
                g_raddr   = scan_idx;
                scan_next = scan_reg + 1'b1;
                state_next = ST_SC_RD;
                if (gvalid_reg[scan_idx] && g_rdata[GW-1:msnp_pkg::STAMP_W] == key) begin
                    slot_next  = scan_idx;
                    state_next = ST_M_RD;
                end else begin
                    if (!gvalid_reg[scan_idx] && !free_ok_reg) begin
                        free_ok_next = 1'b1;
                        free_next    = scan_idx;
                    end
                    if (scan_reg == (SW+1)'(GROUP_SLOTS - 1)) begin
                        if (op_reg == msnp_pkg::OP_JOIN && (free_ok_reg || !gvalid_reg[scan_idx])) begin
                            slot_next  = free_ok_reg ? free_reg : scan_idx;
                            gvalid_next[free_ok_reg ? free_reg : scan_idx] = 1'b1;
                            state_next = ST_CLR;
                        end else begin
                            exist_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_CLR: begin
                m_we    = 1'b1;
                m_waddr = row_base + RW'(pc_idx);
                m_wdata = '0;
                pc_next = pc_reg + 1'b1;
                if (pc_reg == (PW+1)'(PORT_COUNT - 1)) begin
                    state_next = ST_M_RD;
                end
            end
            ST_M_RD: begin
                if (op_reg == msnp_pkg::OP_JOIN) begin
                    g_we = 1'b1;
                end
                state_next = ST_M_WAIT;
            end
            ST_M_WAIT: begin
                state_next = ST_M_WB;
            end
            ST_M_WB: begin
                m_we       = 1'b1;
                exist_next = (op_reg == msnp_pkg::OP_JOIN) ? any_before : any_after;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (exist_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SW_RD: begin
                m_raddr    = row_base + RW'(pc_idx);
                state_next = ST_SW_WT;
            end
            ST_SW_WT: begin
                m_raddr    = row_base + RW'(pc_idx);
                state_next = ST_SW_ACC;
            end
            ST_SW_ACC: begin
                m_raddr = row_base + RW'(pc_idx);
                mask_next[pc_idx] = any_before;
                pc_next = pc_reg + 1'b1;
                state_next = (pc_reg == (PW+1)'(PORT_COUNT - 1)) ? ST_SW_EV : ST_SW_RD;
            end
            ST_SW_EV: begin
                pc_next = '0;
                if (mask_reg == '0) begin
                    gvalid_next[slot_reg] = 1'b0;
                    state_next = ST_IDLE;
                end else if (diff[31]) begin
                    gvalid_next[slot_reg] = 1'b0;
                    state_next = ST_SW_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SW_OUT: begin
                ld_mac  = g_rdata[msnp_pkg::STAMP_W+47:msnp_pkg::STAMP_W];
                ld_vlan = g_rdata[GW-1:msnp_pkg::STAMP_W+48];
                ld_port = 3'(pc_idx);
                ld_act  = msnp_pkg::ACT_REMOVE;
                ld_last = 1'b0;
                if (!mask_reg[pc_idx]) begin
                    pc_next = pc_reg + 1'b1;
                end else if (out_free) begin
                    load = 1'b1;
                    mask_next[pc_idx] = 1'b0;
                    ld_last = (mask_next == '0);
                    pc_next = pc_reg + 1'b1;
                    if (mask_next == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            enable_reg <= 1'b0;
            expire_reg <= msnp_pkg::EXPIRE_RESET;
            gvalid_reg <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            gvalid_reg <= gvalid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    msnp_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                    msnp_pkg::CFG_EXPIRE: expire_reg <= cfg_data;
                endcase
            end
            if (load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            gmac_reg <= s_group_mac;
            hmac_reg <= s_host_mac;
            vlan_reg <= s_vlan;
            port_reg <= s_port;
            now_reg  <= s_now;
        end
        scan_reg    <= scan_next;
        slot_reg    <= slot_next;
        free_ok_reg <= free_ok_next;
        free_reg    <= free_next;
        pc_reg      <= pc_next;
        mask_reg    <= mask_next;
        exist_reg   <= exist_next;
        if (load) begin
            omac_reg  <= ld_mac;
            ovlan_reg <= ld_vlan;
            oport_reg <= ld_port;
            oact_reg  <= ld_act;
            olast_reg <= ld_last;
        end
    end

    assign m_valid         = mv_reg;
    assign m_out_group_mac = omac_reg;
    assign m_out_vlan      = ovlan_reg;
    assign m_out_port      = oport_reg;
    assign m_action        = oact_reg;
    assign m_last          = olast_reg;

endmodule
